// ===== rtl/bslru_pkg.sv =====
// ----------------------------------------------------------------------------
// bslru_pkg
// Shared types and constants for the station table with least-recently-seen
// replacement.
// ----------------------------------------------------------------------------
package bslru_pkg;

  // Widest slot index the table supports (up to 1024 entries).
  localparam int unsigned IDX_MAX_W = 10;

  localparam logic [1:0] REG_STRONG   = 2'd0;
  localparam logic [1:0] REG_MODERATE = 2'd1;
  localparam logic [1:0] REG_WEAK     = 2'd2;

  localparam logic [1:0] CLASS_STRONG   = 2'd0;
  localparam logic [1:0] CLASS_MODERATE = 2'd1;
  localparam logic [1:0] CLASS_WEAK     = 2'd2;
  localparam logic [1:0] CLASS_MARGINAL = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } bslru_state_t;

  typedef struct packed {
    logic [47:0]       station_id;
    logic [63:0]       name_word0;
    logic [63:0]       name_word1;
    logic [63:0]       name_word2;
    logic [63:0]       name_word3;
    logic signed [7:0] signal_dbm;
    logic [7:0]        radio_channel;
    logic [3:0]        auth_kind;
    logic [31:0]       timestamp;
  } bslru_req_t;

  typedef struct packed {
    logic [5:0]        slot_index;
    logic              was_hit;
    logic              did_evict;
    logic [6:0]        occupancy;
    logic [31:0]       eviction_total;
    logic [47:0]       echo_station_id;
    logic signed [7:0] echo_signal_dbm;
    logic [7:0]        echo_channel;
    logic [3:0]        echo_auth_kind;
    logic [1:0]        signal_class;
  } bslru_resp_t;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    logic                 hit_found;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 old_found;
    logic [IDX_MAX_W-1:0] old_idx;
    logic [31:0]          old_time;
  } bslru_probe_t;

  // Entry update broadcast to every cell at the end of a search.
  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    logic [47:0]          key;
    logic [31:0]          seen_time;
  } bslru_wr_t;

endpackage

// ===== rtl/bslru_cell.sv =====
// ----------------------------------------------------------------------------
// bslru_cell
// One table entry. Folds its entry into the passing search token and hands
// the token, through a register, to the next cell.
// ----------------------------------------------------------------------------
module bslru_cell import bslru_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [47:0]  key,
  input  bslru_probe_t probe_in,
  output bslru_probe_t probe_out,
  input  bslru_wr_t    wr
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

  logic         entry_valid;
  logic [47:0]  entry_key;
  logic [31:0]  entry_stamp;
  bslru_probe_t probe_next;

  always_comb begin
    probe_next = probe_in;
    if (!entry_valid) begin
      if (!probe_in.free_found) begin
        probe_next.free_found = 1'b1;
        probe_next.free_idx   = MY_IDX;
      end
    end else if (entry_key == key) begin
      probe_next.hit_found = 1'b1;
      probe_next.hit_idx   = MY_IDX;
    end else if (!probe_in.old_found || (entry_stamp < probe_in.old_time)) begin
      probe_next.old_found = 1'b1;
      probe_next.old_idx   = MY_IDX;
      probe_next.old_time  = entry_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit_found  <= probe_next.hit_found;
    probe_out.hit_idx    <= probe_next.hit_idx;
    probe_out.free_found <= probe_next.free_found;
    probe_out.free_idx   <= probe_next.free_idx;
    probe_out.old_found  <= probe_next.old_found;
    probe_out.old_idx    <= probe_next.old_idx;
    probe_out.old_time   <= probe_next.old_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (wr.en && wr.idx == MY_IDX) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX) begin
      entry_key   <= wr.key;
      entry_stamp <= wr.seen_time;
    end
  end

endmodule

// ===== rtl/bssid_table_lru_upsert_top.sv =====
// ----------------------------------------------------------------------------
// bssid_table_lru_upsert_top
// Station table with least-recently-seen replacement and signal classing.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low. Its
// search token then walks the row of TABLE_DEPTH cells, one cell per clock; when
// it leaves the last cell, done is registered high. The result is shown for
// the single cycle that done is high and cannot be stalled. busy is low in
// the cycle that done is high, so the next request can be taken at the edge
// that ends it; no new request is taken while one is still in the cell row.
// Threshold registers are written through cfg_we; the user must write them
// only while busy is low, as the block itself does not enforce it.
module bssid_table_lru_upsert_top import bslru_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  bslru_req_t  req,
  output logic        done,
  output bslru_resp_t resp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  bslru_state_t state, state_next;
  bslru_req_t   held;
  bslru_probe_t probe_head;
  bslru_probe_t probe [TABLE_DEPTH+1];
  bslru_wr_t    wr;

  logic signed [7:0] strong_thr, moderate_thr, weak_thr;
  logic [CNT_W-1:0]  occ, occ_next;
  logic [31:0]       evictions, evictions_next;
  logic              accept, finish, evict;
  logic [IDX_MAX_W-1:0] slot;
  logic [1:0]        sclass;
  logic [IDX_MAX_W+5:0] slot_ext;
  logic [CNT_W+6:0]  occ_ext;
  logic [47:0]       scan_key;

  assign accept = start && (state == ST_IDLE);

  // The first cell sees the token in the cycle the request is taken,
  // before held is loaded, so it compares against the incoming key.
  assign scan_key = accept ? req.station_id : held.station_id;

  always_comb begin
    probe_head       = '0;
    probe_head.valid = accept;
  end

  assign probe[0] = probe_head;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      bslru_cell #(.CELL_IDX(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .key      (scan_key),
        .probe_in (probe[gi]),
        .probe_out(probe[gi+1]),
        .wr       (wr)
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (probe[TABLE_DEPTH].valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy   = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        busy   = 1'b1;
        finish = probe[TABLE_DEPTH].valid;
      end
      default: busy = 1'b0;
    endcase
  end

  // Pick the slot once the token has seen every entry.
  always_comb begin
    evict = 1'b0;
    if (probe[TABLE_DEPTH].hit_found) begin
      slot = probe[TABLE_DEPTH].hit_idx;
    end else if (probe[TABLE_DEPTH].free_found) begin
      slot = probe[TABLE_DEPTH].free_idx;
    end else begin
      slot  = probe[TABLE_DEPTH].old_idx;
      evict = 1'b1;
    end
    wr.en        = finish;
    wr.idx       = slot;
    wr.key       = held.station_id;
    wr.seen_time = held.timestamp;
    occ_next = occ;
    if (!probe[TABLE_DEPTH].hit_found && !evict) occ_next = occ + CNT_W'(1);
    evictions_next = evictions + {31'd0, evict};
    slot_ext = {6'd0, slot};
    occ_ext  = {7'd0, occ_next};
  end

  // Threshold compares applied strictly in order.
  always_comb begin
    if (held.signal_dbm >= strong_thr) begin
      sclass = CLASS_STRONG;
    end else if (held.signal_dbm >= moderate_thr) begin
      sclass = CLASS_MODERATE;
    end else if (held.signal_dbm >= weak_thr) begin
      sclass = CLASS_WEAK;
    end else begin
      sclass = CLASS_MARGINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      occ       <= '0;
      evictions <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (finish) begin
        occ       <= occ_next;
        evictions <= evictions_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strong_thr   <= -8'sd50;
      moderate_thr <= -8'sd67;
      weak_thr     <= -8'sd80;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRONG:   strong_thr   <= cfg_data;
        REG_MODERATE: moderate_thr <= cfg_data;
        REG_WEAK:     weak_thr     <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req;
    end
    if (finish) begin
      resp.slot_index      <= slot_ext[5:0];
      resp.was_hit         <= probe[TABLE_DEPTH].hit_found;
      resp.did_evict       <= evict;
      resp.occupancy       <= occ_ext[6:0];
      resp.eviction_total  <= evictions_next;
      resp.echo_station_id <= held.station_id;
      resp.echo_signal_dbm <= held.signal_dbm;
      resp.echo_channel    <= held.radio_channel;
      resp.echo_auth_kind  <= held.auth_kind;
      resp.signal_class    <= sclass;
    end
  end

endmodule

// ===== tb/bssid_table_lru_upsert_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssid_table_lru_upsert_top_tb
// Drives station reports into the station table and checks every result
// against a behavioral table kept in the bench, across several threshold
// settings, table fills, refreshes and evictions.
// ----------------------------------------------------------------------------
module bssid_table_lru_upsert_top_tb;
  import bslru_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  bslru_req_t  req;
  logic        done;
  bslru_resp_t resp;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  bssid_table_lru_upsert_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .resp(resp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Behavioral copy of the table and the thresholds.
  logic              tbl_valid [DEPTH];
  logic [47:0]       tbl_key [DEPTH];
  logic [31:0]       tbl_seen [DEPTH];
  logic [31:0]       evict_cnt;
  logic signed [7:0] thr_strong, thr_moderate, thr_weak;

  bslru_req_t  report_queue[$];
  bslru_resp_t expected_results[$];
  int          errors;
  int          cycles;
  bit          idle_free;
  bit          hold_off;

  function automatic logic [1:0] classify(logic signed [7:0] lvl);
    if (lvl >= thr_strong) return CLASS_STRONG;
    if (lvl >= thr_moderate) return CLASS_MODERATE;
    if (lvl >= thr_weak) return CLASS_WEAK;
    return CLASS_MARGINAL;
  endfunction

  function automatic bslru_resp_t upsert(bslru_req_t r);
    bslru_resp_t o;
    int hit, open_slot, oldest, slot, used;
    hit = -1; open_slot = -1; oldest = -1; used = 0;
    o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!tbl_valid[i]) begin
        if (open_slot < 0) open_slot = i;
        continue;
      end
      if (tbl_key[i] == r.station_id) begin
        hit = i;
        break;
      end
      if (oldest < 0 || tbl_seen[i] < tbl_seen[oldest]) oldest = i;
    end
    if (hit >= 0) slot = hit;
    else if (open_slot >= 0) slot = open_slot;
    else begin
      slot = oldest;
      o.did_evict = 1'b1;
      evict_cnt = evict_cnt + 32'd1;
    end
    tbl_valid[slot] = 1'b1;
    tbl_key[slot] = r.station_id;
    tbl_seen[slot] = r.timestamp;
    for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) used++;
    o.slot_index = slot[5:0];
    o.was_hit = (hit >= 0);
    o.occupancy = used[6:0];
    o.eviction_total = evict_cnt;
    o.echo_station_id = r.station_id;
    o.echo_signal_dbm = r.signal_dbm;
    o.echo_channel = r.radio_channel;
    o.echo_auth_kind = r.auth_kind;
    o.signal_class = classify(r.signal_dbm);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic bslru_req_t rand_report(logic [47:0] sid, logic [31:0] ts);
    bslru_req_t r;
    r.station_id = sid;
    r.name_word0 = {$urandom, $urandom};
    r.name_word1 = {$urandom, $urandom};
    r.name_word2 = {$urandom, $urandom};
    r.name_word3 = {$urandom, $urandom};
    r.signal_dbm = 8'($urandom);
    r.radio_channel = 8'($urandom);
    r.auth_kind = 4'($urandom);
    r.timestamp = ts;
    return r;
  endfunction

  function automatic logic [47:0] rand_sid();
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The driver: one request per handshake, random gaps except while idle_free is set.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(upsert(req));
      if (report_queue.size() > 0 && !hold_off &&
          (idle_free || $urandom_range(99) >= 33)) begin
        req <= report_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && report_queue.size() > 0 && !hold_off &&
                 (idle_free || $urandom_range(99) >= 33)) begin
      req <= report_queue.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", 64'd0, 64'd0);
      end else begin
        bslru_resp_t e;
        e = expected_results.pop_front();
        if (resp.slot_index != e.slot_index)
          report_mismatch("slot_index", 64'(resp.slot_index), 64'(e.slot_index));
        if (resp.was_hit != e.was_hit)
          report_mismatch("was_hit", 64'(resp.was_hit), 64'(e.was_hit));
        if (resp.did_evict != e.did_evict)
          report_mismatch("did_evict", 64'(resp.did_evict), 64'(e.did_evict));
        if (resp.occupancy != e.occupancy)
          report_mismatch("occupancy", 64'(resp.occupancy), 64'(e.occupancy));
        if (resp.eviction_total != e.eviction_total)
          report_mismatch("eviction_total", 64'(resp.eviction_total),
                          64'(e.eviction_total));
        if (resp.echo_station_id != e.echo_station_id)
          report_mismatch("echo_station_id", 64'(resp.echo_station_id),
                          64'(e.echo_station_id));
        if (resp.echo_signal_dbm != e.echo_signal_dbm)
          report_mismatch("echo_signal_dbm", 64'(unsigned'(resp.echo_signal_dbm)),
                          64'(unsigned'(e.echo_signal_dbm)));
        if (resp.echo_channel != e.echo_channel)
          report_mismatch("echo_channel", 64'(resp.echo_channel), 64'(e.echo_channel));
        if (resp.echo_auth_kind != e.echo_auth_kind)
          report_mismatch("echo_auth_kind", 64'(resp.echo_auth_kind),
                          64'(e.echo_auth_kind));
        if (resp.signal_class != e.signal_class)
          report_mismatch("signal_class", 64'(resp.signal_class), 64'(e.signal_class));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (report_queue.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_threshold(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STRONG:   thr_strong = val;
      REG_MODERATE: thr_moderate = val;
      REG_WEAK:     thr_weak = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Queues reports that mix refreshes of a pool of known stations with new ones.
  task automatic queue_phase(int count, int pool);
    logic [47:0] known [$];
    for (int i = 0; i < pool; i++) known.push_back(rand_sid());
    for (int i = 0; i < count; i++) begin
      int pick;
      logic [31:0] ts;
      pick = $urandom_range(99);
      ts = (pick < 5) ? $urandom : (cycles + i * 3 + $urandom_range(40));
      if (pick < 10) report_queue.push_back(rand_report(rand_sid(), ts));
      else report_queue.push_back(rand_report(known[$urandom_range(pool - 1)], ts));
    end
  endtask

  initial begin
    bslru_req_t r;
    int lv [6];
    errors = 0; cycles = 0; idle_free = 1'b0; hold_off = 1'b0;
    rst = 1'b1; start = 1'b0; req = '0;
    cfg_we = 1'b0; cfg_index = REG_STRONG; cfg_data = '0;
    thr_strong = -8'sd50; thr_moderate = -8'sd67; thr_weak = -8'sd80;
    evict_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_seen[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, each signal class boundary, hits.
    r = rand_report('0, '0);
    r.signal_dbm = -8'sd128; r.radio_channel = '0; r.auth_kind = '0;
    r.name_word0 = '0; r.name_word1 = '0; r.name_word2 = '0; r.name_word3 = '0;
    report_queue.push_back(r);
    r = rand_report(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    r.signal_dbm = 8'sd127; r.radio_channel = 8'hFF; r.auth_kind = 4'hF;
    r.name_word0 = '1; r.name_word1 = '1; r.name_word2 = '1; r.name_word3 = '1;
    report_queue.push_back(r);
    lv = '{-50, -51, -67, -68, -80, -81};
    for (int k = 0; k < 6; k++) begin
      r = rand_report(48'h1000 + k, 100 + k);
      r.signal_dbm = 8'(lv[k]);
      report_queue.push_back(r);
    end
    r = rand_report(48'h1002, 7); report_queue.push_back(r);
    r = rand_report('0, 5); report_queue.push_back(r);
    wait_drained();

    // Reversed thresholds and an unused register index.
    write_threshold(REG_STRONG, 8'h80);
    write_threshold(REG_MODERATE, 8'h7F);
    write_threshold(REG_WEAK, 8'h00);
    write_threshold(2'd3, 8'h55);
    for (int k = 0; k < 60; k++) begin
      r = rand_report(48'h2000 + k, 32'd1000 + k);
      report_queue.push_back(r);
    end
    // Table now full: wrapped timestamp makes an entry the oldest, then evictions.
    r = rand_report(48'h2003, 32'd0); report_queue.push_back(r);
    for (int k = 0; k < 8; k++) begin
      r = rand_report(48'h3000 + k, 32'd5000 + k);
      report_queue.push_back(r);
    end
    idle_free = 1'b1;
    wait_drained();
    idle_free = 1'b0;

    write_threshold(REG_STRONG, 8'h7F);
    write_threshold(REG_MODERATE, 8'h80);
    write_threshold(REG_WEAK, 8'h80);
    queue_phase(300, 90);
    wait_drained();

    // Sender held off while the table, having answered everything, stands idle.
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;

    write_threshold(REG_STRONG, 8'hEC);
    write_threshold(REG_MODERATE, 8'hC4);
    write_threshold(REG_WEAK, 8'hA6);
    queue_phase(300, 70);
    wait_drained();
    write_threshold(REG_STRONG, 8'hCE);
    write_threshold(REG_MODERATE, 8'hBD);
    write_threshold(REG_WEAK, 8'hB0);
    queue_phase(250, 120);
    wait_drained();
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
